### sv/s256_pkg.sv
// Shared constants of the SHA-256 byte stream hasher: command codes, round constants and IV.
`default_nettype none
package s256_pkg;

   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned HASH_WORDS  = 8;
   localparam int unsigned ROUNDS      = 64;

   localparam logic CMD_FEED   = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] LENGTH_POS = 6'd56;

   localparam logic [31:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

endpackage
`default_nettype wire

### sv/s256_if.sv
// Valid/ready channel interfaces for the request and response sides of the hasher.
`default_nettype none
interface s256_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] data_byte;

   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface s256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last;

   modport source (output valid, output digest_word, output word_index, output last,
                   input ready);
   modport sink (input valid, input digest_word, input word_index, input last,
                 output ready);
endinterface
`default_nettype wire

### sv/sha256_byte_stream_hasher.sv
// SHA-256 hasher over a byte stream with one compression round per cycle.
//
//   Channel   Direction  Beat contents
//   req_if    in         cmd (feed byte or finish), data_byte
//   rsp_if    out        digest_word, word_index, last
//
// A feed beat is taken while idle; the beat that completes a 64-byte block is followed by
// the compression rounds and a fold, and no further beat is taken until these are done.
// A finish beat starts padding, then runs the rounds and a fold for each compressed block
// (one or two), then sends eight response beats.
// Synchronous reset restores the initial hash value and clears the byte and bit counts.
// The response side may stall at any time; the hasher simply holds the current word.
`default_nettype none
module sha256_byte_stream_hasher (
   input  wire logic   clock,
   input  wire logic   reset,
   s256_req_if.sink    req_if,
   s256_rsp_if.source  rsp_if
);
   import s256_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_FOLD  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  round_ff, round_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic        second_ff, second_in;
   logic        finish_ff, finish_in;
   logic [2:0]  word_ff, word_in;
   logic [31:0] blk_ff [BLOCK_WORDS];
   logic [31:0] blk_in [BLOCK_WORDS];
   logic [31:0] v_ff [HASH_WORDS];
   logic [31:0] v_in [HASH_WORDS];
   logic [31:0] h_ff [HASH_WORDS];
   logic [31:0] h_in [HASH_WORDS];
   logic [31:0] sum [HASH_WORDS];
   logic [31:0] t1, t2, w_next;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned r);
      return (x >> r) | (x << (32 - r));
   endfunction

   assign t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
             + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + ROUND_K[round_ff] + blk_ff[0];
   assign t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   assign w_next = blk_ff[0] + blk_ff[9]
                 + (rotr(blk_ff[1], 7) ^ rotr(blk_ff[1], 18) ^ (blk_ff[1] >> 3))
                 + (rotr(blk_ff[14], 17) ^ rotr(blk_ff[14], 19) ^ (blk_ff[14] >> 10));

   always_comb begin
      for (int i = 0; i < HASH_WORDS; i++) begin
         sum[i] = h_ff[i] + v_ff[i];
      end
   end

   always_comb begin
      logic [5:0] idx;
      idx       = '0;
      state_in  = state_ff;
      round_in  = round_ff;
      fill_in   = fill_ff;
      bitlen_in = bitlen_ff;
      second_in = second_ff;
      finish_in = finish_ff;
      word_in   = word_ff;
      blk_in    = blk_ff;
      v_in      = v_ff;
      h_in      = h_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               if (req_if.cmd == CMD_FEED) begin
                  blk_in[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] = req_if.data_byte;
                  bitlen_in = bitlen_ff + 64'd8;
                  fill_in   = fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     v_in      = h_ff;
                     round_in  = '0;
                     finish_in = 1'b0;
                     state_in  = ST_ROUND;
                  end
               end else begin
                  finish_in = 1'b1;
                  state_in  = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            for (int j = 0; j < BLOCK_WORDS; j++) begin
               for (int b = 0; b < 4; b++) begin
                  idx = 6'(4 * j + b);
                  if (idx == fill_ff) begin
                     blk_in[j][8 * (3 - b) +: 8] = PAD_BYTE;
                  end else if (idx > fill_ff) begin
                     blk_in[j][8 * (3 - b) +: 8] = 8'h00;
                  end
               end
            end
            second_in = (fill_ff >= LENGTH_POS);
            if (fill_ff < LENGTH_POS) begin
               blk_in[BLOCK_WORDS - 2] = bitlen_ff[63:32];
               blk_in[BLOCK_WORDS - 1] = bitlen_ff[31:0];
            end
            v_in     = h_ff;
            round_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            v_in[0] = t1 + t2;
            v_in[1] = v_ff[0];
            v_in[2] = v_ff[1];
            v_in[3] = v_ff[2];
            v_in[4] = v_ff[3] + t1;
            v_in[5] = v_ff[4];
            v_in[6] = v_ff[5];
            v_in[7] = v_ff[6];
            for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
               blk_in[j] = blk_ff[j + 1];
            end
            blk_in[BLOCK_WORDS - 1] = w_next;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'(ROUNDS - 1)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            h_in = sum;
            if (!finish_ff) begin
               state_in = ST_IDLE;
            end else if (second_ff) begin
               for (int j = 0; j < BLOCK_WORDS - 2; j++) begin
                  blk_in[j] = '0;
               end
               blk_in[BLOCK_WORDS - 2] = bitlen_ff[63:32];
               blk_in[BLOCK_WORDS - 1] = bitlen_ff[31:0];
               second_in = 1'b0;
               v_in      = sum;
               round_in  = '0;
               state_in  = ST_ROUND;
            end else begin
               word_in  = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_if.ready) begin
               for (int i = 0; i < HASH_WORDS - 1; i++) begin
                  h_in[i] = h_ff[i + 1];
               end
               h_in[HASH_WORDS - 1] = h_ff[0];
               word_in = word_ff + 3'd1;
               if (word_ff == 3'd7) begin
                  h_in      = INIT_HASH;
                  fill_in   = '0;
                  bitlen_in = '0;
                  finish_in = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         round_ff  <= '0;
         fill_ff   <= '0;
         bitlen_ff <= '0;
         second_ff <= 1'b0;
         finish_ff <= 1'b0;
         word_ff   <= '0;
         h_ff      <= INIT_HASH;
      end else begin
         state_ff  <= state_in;
         round_ff  <= round_in;
         fill_ff   <= fill_in;
         bitlen_ff <= bitlen_in;
         second_ff <= second_in;
         finish_ff <= finish_in;
         word_ff   <= word_in;
         h_ff      <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      v_ff   <= v_in;
   end

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = (state_ff == ST_OUT);
   assign rsp_if.digest_word = h_ff[0];
   assign rsp_if.word_index  = word_ff;
   assign rsp_if.last        = (word_ff == 3'd7);

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_if.last)
      |=> (state_ff == ST_IDLE && fill_ff == '0 && bitlen_ff == '0))
      else $error("Hasher did not restart after the final digest beat.");

   a_full_block: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.cmd == CMD_FEED && fill_ff == 6'd63)
      |=> (state_ff == ST_ROUND && round_ff == '0 && fill_ff == '0))
      else $error("A full block did not start a compression.");

   a_finish_pads: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.cmd == CMD_FINISH) |=> (state_ff == ST_PAD))
      else $error("A finish beat did not start padding.");

   a_rounds_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == 6'(ROUNDS - 1)) |=> (state_ff == ST_FOLD))
      else $error("Compression did not fold after the last round.");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (!req_if.ready && finish_ff))
      else $error("Response beat offered outside a finished message.");

endmodule
`default_nettype wire
